// File: hdl/r2h_pkg.sv
// ---------------------------------------------------------------------------
// r2h_pkg: shared types and constants for the RGB to HSL converter
// Pipeline stage map, divider geometry and fixed-point scale constants.
// ---------------------------------------------------------------------------
package r2h_pkg;

  // Pixel channel width
  localparam int CH_W = 8;

  // Restoring divider geometry: quotient is known to stay below 2**DIV_Q_W
  localparam int DIV_NUM_W     = 24;
  localparam int DIV_DEN_W     = 10;
  localparam int DIV_Q_W       = 15;
  localparam int DIV_BITS_STG  = 3;
  localparam int DIV_STAGES    = DIV_Q_W / DIV_BITS_STG;

  // Pipeline stage indexes
  localparam int STG_A      = 0;
  localparam int STG_B      = 1;
  localparam int STG_C      = 2;
  localparam int DIV_FIRST  = 3;
  localparam int STG_OUT    = DIV_FIRST + DIV_STAGES;
  localparam int PIPE_STAGES = STG_OUT + 1;

  // Fixed-point scale constants
  localparam logic [23:0] HUE_NUM_K   = 24'd7680;   // 2 * 3840 (one sextant, q6)
  localparam logic [23:0] SAT_NUM_K   = 24'd51200;  // 2 * 25600 (100 percent, q8)
  localparam logic [23:0] LIGHT_NUM_K = 24'd5120;
  localparam logic [23:0] LIGHT_BIAS  = 24'd51;
  localparam logic [9:0]  LIGHT_DEN   = 10'd102;
  localparam logic [14:0] HUE_FULL_Q6 = 15'd23040;

  // Which channel holds the maximum, in hue priority order
  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } hue_sel_t;

endpackage

// File: hdl/r2h_div.sv
// ---------------------------------------------------------------------------
// r2h_div: pipelined restoring divider
// Produces floor(num/den) over several register stages, a few quotient bits
// per stage. Stage loads come from the owning pipeline's flow control.
// ---------------------------------------------------------------------------
module r2h_div (
  input  logic                               clk,
  input  logic [r2h_pkg::DIV_STAGES-1:0]     ld,
  input  logic [r2h_pkg::DIV_NUM_W-1:0]      num_i,
  input  logic [r2h_pkg::DIV_DEN_W-1:0]      den_i,
  output logic [r2h_pkg::DIV_Q_W-1:0]        quo_o
);

  localparam int NW  = r2h_pkg::DIV_NUM_W;
  localparam int DW  = r2h_pkg::DIV_DEN_W;
  localparam int QW  = r2h_pkg::DIV_Q_W;
  localparam int NS  = r2h_pkg::DIV_STAGES;
  localparam int BPS = r2h_pkg::DIV_BITS_STG;

  logic [DW-1:0] rem_r [NS];
  logic [QW-1:0] low_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [QW-1:0] quo_r [NS];

  logic [DW-1:0] rem_nxt [NS];
  logic [QW-1:0] low_nxt [NS];
  logic [DW-1:0] den_nxt [NS];
  logic [QW-1:0] quo_nxt [NS];

  always_comb begin
    logic [DW-1:0] rem;
    logic [QW-1:0] low;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic [DW:0]   part;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        // top bits of the numerator are already below the divisor
        rem = DW'(num_i[NW-1:QW]);
        low = num_i[QW-1:0];
        den = den_i;
        quo = '0;
      end else begin
        rem = rem_r[s-1];
        low = low_r[s-1];
        den = den_r[s-1];
        quo = quo_r[s-1];
      end
      for (int j = 0; j < BPS; j++) begin
        part = {rem, low[QW-1]};
        low  = {low[QW-2:0], 1'b0};
        if (part >= {1'b0, den}) begin
          rem = DW'(part - {1'b0, den});
          quo = {quo[QW-2:0], 1'b1};
        end else begin
          rem = part[DW-1:0];
          quo = {quo[QW-2:0], 1'b0};
        end
      end
      rem_nxt[s] = rem;
      low_nxt[s] = low;
      den_nxt[s] = den;
      quo_nxt[s] = quo;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (ld[s]) begin
        rem_r[s] <= rem_nxt[s];
        low_r[s] <= low_nxt[s];
        den_r[s] <= den_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign quo_o = quo_r[NS-1];

endmodule

// File: hdl/rgb_to_hsl_converter_top.sv
// ---------------------------------------------------------------------------
// rgb_to_hsl_converter_top: streaming RGB to HSL pixel converter
// Converts packed 24-bit RGB pixels to hue (q6 degrees), saturation and
// lightness (q8 percent), rounded to nearest with ties up.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled. The pipeline is
// made up of three front stages (min/max, sextant numerator, scaled
// numerators), five stages of three parallel restoring dividers at three
// quotient bits per stage, and one output register. Each stage advances on
// its own, so a stall on the output only holds back the input once every
// stage is full; bubbles close up. Gray pixels give zero hue and saturation.
module rgb_to_hsl_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_pixel_rgb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_hue_q6,
  output logic [14:0] out_saturation_q8,
  output logic [14:0] out_lightness_q8
);

  localparam int NP = r2h_pkg::PIPE_STAGES;
  localparam int CW = r2h_pkg::CH_W;
  localparam int NW = r2h_pkg::DIV_NUM_W;
  localparam int DW = r2h_pkg::DIV_DEN_W;
  localparam int QW = r2h_pkg::DIV_Q_W;

  // ---------------- flow control ----------------
  logic [NP-1:0] v_r, v_nxt, free, inc_v, ld;

  always_comb begin
    for (int k = NP - 1; k >= 0; k--) begin
      if (k == NP - 1) begin
        free[k] = !v_r[k] || !out_stall;
      end else begin
        free[k] = !v_r[k] || free[k+1];
      end
      inc_v[k] = (k == 0) ? in_valid : v_r[k-1];
      ld[k]    = free[k] && inc_v[k];
      v_nxt[k] = free[k] ? inc_v[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !free[0];
  assign out_valid = v_r[NP-1];

  // ---------------- stage A: max, min, hue channel ----------------
  logic [CW-1:0] r_in, g_in, b_in, hi_nxt, lo_nxt;
  r2h_pkg::hue_sel_t sel_nxt;
  logic [CW-1:0] ra_r, ga_r, ba_r, hi_a_r, lo_a_r;
  r2h_pkg::hue_sel_t sel_a_r;

  assign r_in = in_pixel_rgb[23:16];
  assign g_in = in_pixel_rgb[15:8];
  assign b_in = in_pixel_rgb[7:0];

  always_comb begin
    logic [CW-1:0] m;
    logic [CW-1:0] n;
    m      = (r_in > g_in) ? r_in : g_in;
    hi_nxt = (m > b_in) ? m : b_in;
    n      = (r_in < g_in) ? r_in : g_in;
    lo_nxt = (n < b_in) ? n : b_in;
    if (hi_nxt == r_in) begin
      sel_nxt = r2h_pkg::SEL_RED;
    end else if (hi_nxt == g_in) begin
      sel_nxt = r2h_pkg::SEL_GREEN;
    end else begin
      sel_nxt = r2h_pkg::SEL_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[r2h_pkg::STG_A]) begin
      ra_r    <= r_in;
      ga_r    <= g_in;
      ba_r    <= b_in;
      hi_a_r  <= hi_nxt;
      lo_a_r  <= lo_nxt;
      sel_a_r <= sel_nxt;
    end
  end

  // ---------------- stage B: delta, sum, sextant numerator ----------------
  logic [CW-1:0] delta_nxt, den_nxt;
  logic [CW:0]   sum_nxt;
  logic [10:0]   n_nxt;
  logic [CW-1:0] delta_b_r, den_b_r;
  logic [CW:0]   sum_b_r;
  logic [10:0]   n_b_r;
  logic          gray_b_r;

  always_comb begin
    logic [10:0] d11;
    delta_nxt = hi_a_r - lo_a_r;
    sum_nxt   = {1'b0, hi_a_r} + {1'b0, lo_a_r};
    den_nxt   = (sum_nxt < 9'd255) ? sum_nxt[CW-1:0] : CW'(9'd510 - sum_nxt);
    d11       = {3'b000, delta_nxt};
    // modular 11-bit math: every result lands in 0..1530
    case (sel_a_r)
      r2h_pkg::SEL_RED: begin
        if (ga_r >= ba_r) begin
          n_nxt = 11'(ga_r) - 11'(ba_r);
        end else begin
          n_nxt = 11'(d11 * 11'd6) - (11'(ba_r) - 11'(ga_r));
        end
      end
      r2h_pkg::SEL_GREEN: n_nxt = (d11 << 1) + 11'(ba_r) - 11'(ra_r);
      r2h_pkg::SEL_BLUE:  n_nxt = (d11 << 2) + 11'(ra_r) - 11'(ga_r);
      default:            n_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[r2h_pkg::STG_B]) begin
      delta_b_r <= delta_nxt;
      sum_b_r   <= sum_nxt;
      den_b_r   <= den_nxt;
      n_b_r     <= n_nxt;
      gray_b_r  <= (delta_nxt == '0);
    end
  end

  // ---------------- stage C: scaled numerators and divisors ----------------
  // Gray pixels divide 0 by 1 so hue and saturation come out zero.
  logic [NW-1:0] hue_num_c_r, sat_num_c_r, light_num_c_r;
  logic [DW-1:0] hue_den_c_r, sat_den_c_r;

  always_ff @(posedge clk) begin
    if (ld[r2h_pkg::STG_C]) begin
      if (gray_b_r) begin
        hue_num_c_r <= '0;
        hue_den_c_r <= DW'(1);
        sat_num_c_r <= '0;
        sat_den_c_r <= DW'(1);
      end else begin
        hue_num_c_r <= NW'(NW'(n_b_r) * r2h_pkg::HUE_NUM_K) + NW'(delta_b_r);
        hue_den_c_r <= DW'({delta_b_r, 1'b0});
        sat_num_c_r <= NW'(NW'(delta_b_r) * r2h_pkg::SAT_NUM_K) + NW'(den_b_r);
        sat_den_c_r <= DW'({den_b_r, 1'b0});
      end
      light_num_c_r <= NW'(NW'(sum_b_r) * r2h_pkg::LIGHT_NUM_K) + r2h_pkg::LIGHT_BIAS;
    end
  end

  // ---------------- dividers ----------------
  logic [r2h_pkg::DIV_STAGES-1:0] div_ld;
  logic [QW-1:0] hue_quo, sat_quo, light_quo;

  assign div_ld = ld[r2h_pkg::DIV_FIRST +: r2h_pkg::DIV_STAGES];

  r2h_div u_div_hue (
    .clk   (clk),
    .ld    (div_ld),
    .num_i (hue_num_c_r),
    .den_i (hue_den_c_r),
    .quo_o (hue_quo)
  );

  r2h_div u_div_sat (
    .clk   (clk),
    .ld    (div_ld),
    .num_i (sat_num_c_r),
    .den_i (sat_den_c_r),
    .quo_o (sat_quo)
  );

  r2h_div u_div_light (
    .clk   (clk),
    .ld    (div_ld),
    .num_i (light_num_c_r),
    .den_i (r2h_pkg::LIGHT_DEN),
    .quo_o (light_quo)
  );

  // ---------------- output stage ----------------
  logic [QW-1:0] hue_wrap;
  logic [QW-1:0] hue_r, sat_r, light_r;

  // drop a full turn when hue rounds up to 360 degrees
  assign hue_wrap = (hue_quo >= r2h_pkg::HUE_FULL_Q6) ? hue_quo - r2h_pkg::HUE_FULL_Q6
                                                       : hue_quo;

  always_ff @(posedge clk) begin
    if (ld[r2h_pkg::STG_OUT]) begin
      hue_r   <= hue_wrap;
      sat_r   <= sat_quo;
      light_r <= light_quo;
    end
  end

  assign out_hue_q6        = hue_r;
  assign out_saturation_q8 = sat_r;
  assign out_lightness_q8  = light_r;

endmodule

// File: hdl/r2h_checker.sv
// ---------------------------------------------------------------------------
// r2h_checker: port-level checks for the RGB to HSL converter
// Watches the top level's ports only; attached by bind.
// ---------------------------------------------------------------------------
module r2h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [14:0] out_hue_q6,
  input logic [14:0] out_saturation_q8,
  input logic [14:0] out_lightness_q8
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue_q6) &&
      $stable(out_saturation_q8) && $stable(out_lightness_q8))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_q6 < 15'd23040 && out_saturation_q8 <= 15'd25600 &&
      out_lightness_q8 <= 15'd25600)
    else $error("result field out of range");

  // a nonzero hue always comes with nonzero saturation
  a_hue_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hue_q6 != 15'd0 |-> out_saturation_q8 != 15'd0)
    else $error("hue without saturation");

  // the input stalls only when a full pipe sits behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule

bind rgb_to_hsl_converter_top r2h_checker u_r2h_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hue_q6        (out_hue_q6),
  .out_saturation_q8 (out_saturation_q8),
  .out_lightness_q8  (out_lightness_q8)
);

// File: test/tb_rgb_to_hsl_converter_top.sv
// ---------------------------------------------------------------------------
// tb_rgb_to_hsl_converter_top: self-checking bench for the RGB to HSL converter
// Drives packed pixels through the valid/stall input channel and checks each
// hue, saturation and lightness beat against an integer predictor of the
// conversion. Both channels idle at random, and the output is held off for a
// long stretch so the pipeline fills and stalls its input.
// ---------------------------------------------------------------------------
module tb_rgb_to_hsl_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int LONG_HOLD      = 80;
  localparam int unsigned PCT_Q8_FULL = 25600;
  localparam int unsigned SEXTANT_Q6  = 3840;

  typedef struct packed {
    logic [14:0] hue;
    logic [14:0] sat;
    logic [14:0] light;
  } hsl_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] in_pixel_rgb;
  logic        out_valid;
  logic        out_stall;
  logic [14:0] out_hue_q6;
  logic [14:0] out_saturation_q8;
  logic [14:0] out_lightness_q8;

  hsl_t        hsl_expected_q[$];
  int unsigned error_count = 0;
  int unsigned pixels_sent;
  int unsigned results_checked = 0;
  int unsigned gray_pixels;
  int unsigned idle_cycles = 0;
  bit          sender_gaps_on;
  bit          receiver_stalls_on;
  bit          hold_request;

  rgb_to_hsl_converter_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel_rgb      (in_pixel_rgb),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hue_q6        (out_hue_q6),
    .out_saturation_q8 (out_saturation_q8),
    .out_lightness_q8  (out_lightness_q8)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Round num/den to nearest, ties up
  function automatic int unsigned nearest_ratio(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic hsl_t convert_pixel(logic [23:0] px);
    int unsigned r, g, b, hi, lo, delta, sum, den, sextant_num, hue;
    r2h_pkg::hue_sel_t sel;
    hsl_t        res;
    r     = px[23:16];
    g     = px[15:8];
    b     = px[7:0];
    hi    = (r > g) ? r : g;
    hi    = (hi > b) ? hi : b;
    lo    = (r < g) ? r : g;
    lo    = (lo < b) ? lo : b;
    delta = hi - lo;
    sum   = hi + lo;
    res.light = 15'(nearest_ratio(PCT_Q8_FULL * sum, 510));
    res.hue   = '0;
    res.sat   = '0;
    if (delta != 0) begin
      den     = (sum < 255) ? sum : (510 - sum);
      res.sat = 15'(nearest_ratio(PCT_Q8_FULL * delta, den));
      // ties go to red, then green
      if (hi == r) sel = r2h_pkg::SEL_RED;
      else if (hi == g) sel = r2h_pkg::SEL_GREEN;
      else sel = r2h_pkg::SEL_BLUE;
      case (sel)
        r2h_pkg::SEL_RED: begin
          // wrap a negative red sextant up by a full turn
          if (g >= b) sextant_num = g - b;
          else sextant_num = 6 * delta - (b - g);
        end
        r2h_pkg::SEL_GREEN: sextant_num = 2 * delta + b - r;
        default:            sextant_num = 4 * delta + r - g;
      endcase
      hue = nearest_ratio(SEXTANT_Q6 * sextant_num, delta);
      if (hue >= r2h_pkg::HUE_FULL_Q6) hue = hue - r2h_pkg::HUE_FULL_Q6;
      res.hue = 15'(hue);
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 40);
  endfunction

  function automatic logic [23:0] random_pixel();
    int unsigned kind, base, other;
    logic [7:0]  ch[3];
    kind = $urandom_range(0, 9);
    base  = $urandom_range(0, 255);
    other = $urandom_range(0, 255);
    if (kind <= 6) return 24'($urandom());
    if (kind == 7) begin
      // near gray: small delta, stresses the divider with tiny denominators
      for (int i = 0; i < 3; i++) begin
        ch[i] = 8'((base + $urandom_range(0, 3) > 255) ? 255 : base + $urandom_range(0, 3));
      end
      return {ch[0], ch[1], ch[2]};
    end
    if (kind == 8) begin
      // two channels tied, to hit the hue priority
      case ($urandom_range(0, 2))
        0:       return {8'(base), 8'(base), 8'(other)};
        1:       return {8'(base), 8'(other), 8'(base)};
        default: return {8'(other), 8'(base), 8'(base)};
      endcase
    end
    // channels pinned to the rails
    for (int i = 0; i < 3; i++) begin
      ch[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    ch[$urandom_range(0, 2)] = 8'(other);
    return {ch[0], ch[1], ch[2]};
  endfunction

  task automatic send_pixel(input logic [23:0] px);
    int unsigned gap;
    gap = sender_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid     = 1'b0;
      in_pixel_rgb = 24'($urandom());
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_pixel_rgb = px;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    hsl_expected_q.push_back(convert_pixel(px));
    pixels_sent++;
    if (px[23:16] == px[15:8] && px[15:8] == px[7:0]) gray_pixels++;
  endtask

  task automatic test_directed_pixels();
    logic [23:0] corners[$] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0080, 24'hFF0001, 24'hFE0000,
      24'hFE0001, 24'h010000, 24'hFFFEFE, 24'h7F8080, 24'h807F7F, 24'h0000FE,
      24'h01FF00, 24'h123456, 24'hEDCBA9, 24'hAAAAAB
    };
    foreach (corners[i]) send_pixel(corners[i]);
  endtask

  task automatic test_back_to_back();
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    repeat (100) send_pixel(random_pixel());
  endtask

  task automatic test_output_holdoff();
    sender_gaps_on = 1'b0;
    hold_request   = 1'b1;
    // keep offering beats while the receiver holds; the pipeline fills up
    repeat (40) send_pixel(random_pixel());
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  task automatic test_random_pixels();
    for (int i = 0; i < 640; i++) begin
      // idle on both sides in every stretch but the third, which runs without gaps
      if (i % 160 == 0) begin
        sender_gaps_on     = (i != 320);
        receiver_stalls_on = (i != 320);
      end
      send_pixel(random_pixel());
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned len;
    bit          hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
        out_stall = 1'b0;
      end else begin
        len = (receiver_stalls_on && $urandom_range(0, 3) == 0) ? 1 + pick_gap() : 0;
        if (len > 0) begin
          out_stall = 1'b1;
          repeat (len) @(negedge clk);
        end
        out_stall = 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    hsl_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hsl_expected_q.size() == 0) begin
        $error("unexpected result beat: hue %0d sat %0d light %0d",
               out_hue_q6, out_saturation_q8, out_lightness_q8);
        error_count++;
      end else begin
        want = hsl_expected_q.pop_front();
        results_checked++;
        if (out_hue_q6 !== want.hue) begin
          $error("out_hue_q6: expected %0d, got %0d", want.hue, out_hue_q6);
          error_count++;
        end
        if (out_saturation_q8 !== want.sat) begin
          $error("out_saturation_q8: expected %0d, got %0d", want.sat, out_saturation_q8);
          error_count++;
        end
        if (out_lightness_q8 !== want.light) begin
          $error("out_lightness_q8: expected %0d, got %0d", want.light, out_lightness_q8);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_pixel_rgb       = '0;
    pixels_sent        = 0;
    gray_pixels        = 0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    hold_request       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_pixels();
    test_back_to_back();
    test_output_holdoff();
    test_random_pixels();

    @(negedge clk);
    in_valid           = 1'b0;
    receiver_stalls_on = 1'b0;
    while (hsl_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d gray), checked %0d results,",
             pixels_sent, gray_pixels, results_checked);
    $display("covering rails, hue ties, near-gray pixels and a long output hold-off.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/r2h_pkg.sv
hdl/r2h_div.sv
hdl/rgb_to_hsl_converter_top.sv
hdl/r2h_checker.sv
test/tb_rgb_to_hsl_converter_top.sv
